FILE: sv/m2m_pkg.sv
// Shared types and constants for the memory-to-memory CPU step unit.
package m2m_pkg;

    // Request transaction as seen on the input channel
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] load_word;
    } req_t;

    // Result transaction as seen on the output channel
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] print_value;
        logic [8:0]         pc_value;
    } rsp_t;

    // Item class decided by the front end
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // Queue entry between front and back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
    } q_item_t;

    // Request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // Opcodes
    localparam logic [7:0] OP_STORE = 8'd0;
    localparam logic [7:0] OP_PRINT = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_AND   = 8'd6;
    localparam logic [7:0] OP_OR    = 8'd7;
    localparam logic [7:0] OP_XOR   = 8'd8;
    localparam logic [7:0] OP_NOT   = 8'd9;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PRINTED  = 3'd1;
    localparam logic [2:0] ST_PROT     = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO = 3'd3;
    localparam logic [2:0] ST_MEM_FULL = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

endpackage

FILE: sv/m2m_ram.sv
// Generic single-write, single-read RAM with registered read data.
module m2m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/m2m_front.sv
// Front end: accepts request transactions, classifies them and queues them.
module m2m_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  m2m_pkg::req_t     req,
    output logic              item_valid,
    input  logic              item_pop,
    output m2m_pkg::q_item_t  item
);
    import m2m_pkg::*;

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    q_item_t    in_item;

    // Classify the incoming transaction
    always_comb
    begin
        in_item.kind = (req.req_type == REQ_LOAD) ? KIND_LOAD : KIND_STEP;
        in_item.word = req.load_word;
    end

    assign req_stall  = (cnt_reg == 2'd2);
    assign push       = req_valid && !req_stall;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/m2m_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
module m2m_div #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] dividend,
    input  logic [WORD_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] quotient
);

    localparam int WW = WORD_WIDTH;
    localparam int CW = $clog2(WW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [WW:0]   rem_reg, rem_next;
    logic [WW-1:0] quo_reg, quo_next;
    logic [WW-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [WW:0]   shifted;
    logic [WW:0]   diff;

    // One restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg[WW-1:0], quo_reg[WW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WW);
            rem_next  = '0;
            quo_next  = dividend[WW-1] ? (-dividend) : dividend;
            dvs_next  = divisor[WW-1] ? (-divisor) : divisor;
            neg_next  = dividend[WW-1] ^ divisor[WW-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WW])
            begin
                rem_next = diff;
                quo_next = {quo_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[WW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (-quo_reg) : quo_reg;

endmodule

FILE: sv/m2m_back.sv
// Back end: executes queued loads and steps against the data memory.
module m2m_back #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_pop,
    input  m2m_pkg::q_item_t item,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output m2m_pkg::rsp_t    rsp
);
    import m2m_pkg::*;

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int PCW = $clog2(MEM_DEPTH + 1);
    localparam int WW  = WORD_WIDTH;
    localparam logic [8:0]     DEPTH9  = 9'(MEM_DEPTH);
    localparam logic [PCW-1:0] DEPTH_P = PCW'(MEM_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_PRINT = 7'b0000100,
        S_SRCA  = 7'b0001000,
        S_SRCB  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_WRITE = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [PCW-1:0] plen_reg, plen_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [7:0]     op_reg, op_next;
    logic [7:0]     dest_reg, dest_next;
    logic [7:0]     src1_reg, src1_next;
    logic [7:0]     src2_reg, src2_next;
    logic [WW-1:0]  a_reg, a_next;
    logic [WW-1:0]  wval_reg, wval_next;
    logic [MEM_DEPTH-1:0] vld_reg, vld_next;
    logic           vld_q_reg, vld_q_next;
    logic           out_valid_reg, out_valid_next;
    rsp_t           rsp_reg, rsp_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [WW-1:0]  wdata;
    logic           re;
    logic [7:0]     raddr8;
    logic [WW-1:0]  ram_q;
    logic [WW-1:0]  rd_word;
    logic signed [WW-1:0] rd_signed;
    logic [31:0]    instr;
    logic [7:0]     op_dec;
    logic [WW-1:0]  b_word;
    logic [WW-1:0]  prod;
    logic           div_start;
    logic           div_done;
    logic [WW-1:0]  div_q;
    logic           out_free;

    m2m_ram #(
        .WIDTH (WW),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr8[AW-1:0]),
        .rdata (ram_q)
    );

    m2m_div #(
        .WORD_WIDTH (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_word),
        .done     (div_done),
        .quotient (div_q)
    );

    // Words never written, or outside the memory, read as zero
    assign rd_word   = vld_q_reg ? ram_q : '0;
    assign rd_signed = rd_word;
    assign instr     = 32'(rd_signed);
    assign op_dec    = instr[31:24];
    assign b_word    = rd_word;
    assign prod      = a_reg * b_word;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        plen_next      = plen_reg;
        pc_next        = pc_reg;
        op_next        = op_reg;
        dest_next      = dest_reg;
        src1_next      = src1_reg;
        src2_next      = src2_reg;
        a_next         = a_reg;
        wval_next      = wval_reg;
        vld_next       = vld_reg;
        vld_q_next     = vld_q_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        item_pop       = 1'b0;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        re             = 1'b0;
        raddr8         = '0;
        div_start      = 1'b0;

        rsp_next.print_value = '0;
        rsp_next.pc_value    = 9'(pc_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    item_pop = 1'b1;
                    if (item.kind == KIND_LOAD)
                    begin
                        out_valid_next = 1'b1;
                        if (plen_reg == DEPTH_P)
                        begin
                            rsp_next.status = ST_MEM_FULL;
                        end
                        else
                        begin
                            we                          = 1'b1;
                            waddr                       = plen_reg[AW-1:0];
                            wdata                       = item.word[WW-1:0];
                            vld_next[plen_reg[AW-1:0]]  = 1'b1;
                            plen_next                   = plen_reg + PCW'(1);
                            rsp_next.status             = ST_OK;
                        end
                    end
                    else if (pc_reg >= plen_reg)
                    begin
                        out_valid_next  = 1'b1;
                        rsp_next.status = ST_END;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr8     = 8'(pc_reg[AW-1:0]);
                        vld_q_next = vld_reg[pc_reg[AW-1:0]];
                        state_next = S_FETCH;
                    end
                end
            end

            // Decode the fetched word; a store goes to write-back, others issue their first operand read
            S_FETCH:
            begin
                pc_next = pc_reg + PCW'(1);
                op_next = op_dec;
                if (op_dec != OP_PRINT)
                begin
                    dest_next = instr[23:16];
                    src1_next = instr[15:8];
                    src2_next = instr[7:0];
                end
                if (op_dec == OP_STORE)
                begin
                    wval_next  = WW'(instr[7:0]);
                    state_next = S_WRITE;
                end
                else if (op_dec == OP_PRINT)
                begin
                    re         = 1'b1;
                    raddr8     = dest_reg;
                    vld_q_next = (9'(dest_reg) < DEPTH9) && vld_reg[dest_reg[AW-1:0]];
                    state_next = S_PRINT;
                end
                else
                begin
                    re         = 1'b1;
                    raddr8     = instr[15:8];
                    vld_q_next = (9'(instr[15:8]) < DEPTH9)
                                 && vld_reg[instr[15+AW-8:8]];
                    state_next = S_SRCA;
                end
            end

            S_PRINT:
            begin
                out_valid_next       = 1'b1;
                rsp_next.status      = ST_PRINTED;
                rsp_next.print_value = instr;
                state_next           = S_IDLE;
            end

            S_SRCA:
            begin
                a_next     = rd_word;
                re         = 1'b1;
                raddr8     = src2_reg;
                vld_q_next = (9'(src2_reg) < DEPTH9) && vld_reg[src2_reg[AW-1:0]];
                state_next = S_SRCB;
            end

            // ALU operation on the operands; a divide starts the divider or reports division by zero
            S_SRCB:
            begin
                state_next = S_WRITE;
                unique case (op_reg)
                    OP_ADD:  wval_next = a_reg + b_word;
                    OP_SUB:  wval_next = a_reg - b_word;
                    OP_MUL:  wval_next = prod;
                    OP_DIV:
                    begin
                        if (b_word == '0)
                        begin
                            out_valid_next  = 1'b1;
                            rsp_next.status = ST_DIV_ZERO;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_AND:  wval_next = a_reg & b_word;
                    OP_OR:   wval_next = a_reg | b_word;
                    OP_XOR:  wval_next = a_reg ^ b_word;
                    OP_NOT:  wval_next = ~b_word;
                    default: wval_next = '0;
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    wval_next  = div_q;
                    state_next = S_WRITE;
                end
            end

            // Write back unless the target is program area or out of range
            S_WRITE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                if ((9'(dest_reg) < 9'(plen_reg)) || (9'(dest_reg) >= DEPTH9))
                begin
                    rsp_next.status = ST_PROT;
                end
                else
                begin
                    we                         = 1'b1;
                    waddr                      = dest_reg[AW-1:0];
                    wdata                      = wval_reg;
                    vld_next[dest_reg[AW-1:0]] = 1'b1;
                    rsp_next.status            = ST_OK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plen_reg      <= '0;
            pc_reg        <= '0;
            op_reg        <= '0;
            dest_reg      <= '0;
            src1_reg      <= '0;
            src2_reg      <= '0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            pc_reg        <= pc_next;
            op_reg        <= op_next;
            dest_reg      <= dest_next;
            src1_reg      <= src1_next;
            src2_reg      <= src2_next;
            vld_reg       <= vld_next;
            vld_q_reg     <= vld_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register holds still while a stalled transaction waits
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        wval_reg <= wval_next;
        if (out_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/mem_to_mem_cpu_step_unit.sv
// Load and end of program answer from idle; store goes fetch, write; print goes fetch, print;
// ALU op goes fetch, operand A, operand B, write; divide adds the bit-serial divider.
// The back-end sequencer and its single RAM port execute one transaction at a time.
// A two-entry queue takes new transactions while the back end works.
// Reset (async, active low) clears counters, operand bytes and per-word valid
// bits, so the memory reads as zero at once with no clearing pass.
module mem_to_mem_cpu_step_unit #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  m2m_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output m2m_pkg::rsp_t rsp
);
    import m2m_pkg::*;

    q_item_t item;
    logic    item_valid;
    logic    item_pop;

    m2m_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    m2m_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
